@@ rtl/btd_pkg.sv @@
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types and constants for the BER TLV stream decoder.
// ----------------------------------------------------------------------------
package btd_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam logic [7:0] MAX_ARCS_RESET = 8'd128;
    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [7:0] TAG_NULL = 8'h05;
    localparam logic [7:0] TAG_OID = 8'h06;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN0,
        PH_LENMORE,
        PH_VALUE,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TAG,
        KIND_LEN,
        KIND_VALUE,
        KIND_DISCARD
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_LEN_COUNT,
        ERR_TRUNCATED,
        ERR_INT_SIZE,
        ERR_NULL_LEN,
        ERR_EMPTY_OID,
        ERR_ARCS
    } err_t;

    typedef enum logic [1:0] {
        AFLAG_NONE,
        AFLAG_FIRST,
        AFLAG_LATER
    } aflag_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        buf_end;
    } req_t;

    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  data_byte;
        logic [7:0]  tag_value;
        logic [31:0] content_length;
        logic        element_done;
        logic [63:0] int_value;
        logic        int_valid;
        logic [2:0]  first_arc;
        logic [31:0] arc_value;
        logic [1:0]  arc_flag;
        logic [2:0]  error_code;
    } res_t;

endpackage

@@ rtl/btd_front.sv @@
// ----------------------------------------------------------------------------
// btd_front
// Input stage: accepts requests and places them in a short queue.
// ----------------------------------------------------------------------------
module btd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  btd_pkg::req_t   req,
    output logic            q_valid,
    input  logic            q_ready,
    output btd_pkg::req_t   q_req
);

    localparam int DEPTH = btd_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);

    btd_pkg::req_t       mem_reg [DEPTH];
    logic [AW-1:0]       wptr_reg, wptr_next;
    logic [AW-1:0]       rptr_reg, rptr_next;
    logic [AW:0]         cnt_reg, cnt_next;
    logic                push, pop;

    assign ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign q_valid = (cnt_reg != '0);
    assign q_req = mem_reg[rptr_reg];
    assign push = valid & ready;
    assign pop = q_valid & q_ready;

    always_comb
    begin
        wptr_next = push ? wptr_reg + AW'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + AW'(1) : rptr_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= req;
        end
    end

endmodule

@@ rtl/btd_back.sv @@
// ----------------------------------------------------------------------------
// btd_back
// Parser: steps the TLV state per byte and registers one result.
// ----------------------------------------------------------------------------
module btd_back #(
    parameter int MAX_LENGTH_BYTES = btd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  btd_pkg::req_t   q_req,
    input  logic [7:0]      max_arcs,
    output logic            out_valid,
    input  logic            out_ready,
    output btd_pkg::res_t   res
);

    btd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [6:0]  lbl_reg, lbl_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] vleft_reg, vleft_next;
    logic [63:0] iacc_reg, iacc_next;
    logic [31:0] aacc_reg, aacc_next;
    logic [7:0]  acnt_reg, acnt_next;
    logic        first_reg, first_next;
    logic        ov_reg;
    btd_pkg::res_t res_reg, r;
    logic        take, len_ready;
    logic [7:0]  b;
    logic [31:0] aacc_new;
    logic [63:0] iacc_new;
    logic [2:0]  q40;

    assign q_ready = !ov_reg || out_ready;
    assign take = q_valid & q_ready;
    assign out_valid = ov_reg;
    assign res = res_reg;
    assign b = q_req.data_byte;

    always_comb
    begin
        if (b >= 8'd240) q40 = 3'd6;
        else if (b >= 8'd200) q40 = 3'd5;
        else if (b >= 8'd160) q40 = 3'd4;
        else if (b >= 8'd120) q40 = 3'd3;
        else if (b >= 8'd80) q40 = 3'd2;
        else if (b >= 8'd40) q40 = 3'd1;
        else q40 = 3'd0;
    end

    always_comb
    begin
        phase_next = phase_reg;
        tag_next = tag_reg;
        lbl_next = lbl_reg;
        lacc_next = lacc_reg;
        vleft_next = vleft_reg;
        iacc_next = iacc_reg;
        aacc_next = aacc_reg;
        acnt_next = acnt_reg;
        first_next = first_reg;
        len_ready = 1'b0;
        r = '0;
        r.byte_kind = btd_pkg::KIND_DISCARD;
        r.data_byte = b;
        iacc_new = first_reg ? {{56{b[7]}}, b} : {iacc_reg[55:0], b};
        aacc_new = {aacc_reg[24:0], b[6:0]};
        case (phase_reg)
            btd_pkg::PH_TAG:
            begin
                r.byte_kind = btd_pkg::KIND_TAG;
                tag_next = b;
                lacc_next = '0;
                vleft_next = '0;
                phase_next = btd_pkg::PH_LEN0;
            end
            btd_pkg::PH_LEN0:
            begin
                r.byte_kind = btd_pkg::KIND_LEN;
                if (!b[7])
                begin
                    lacc_next = {24'd0, b};
                    len_ready = 1'b1;
                end
                else if (b[6:0] == 7'd0 || b[6:0] > 7'(MAX_LENGTH_BYTES))
                begin
                    r.error_code = btd_pkg::ERR_LEN_COUNT;
                    phase_next = btd_pkg::PH_DISCARD;
                end
                else
                begin
                    lbl_next = b[6:0];
                    lacc_next = '0;
                    phase_next = btd_pkg::PH_LENMORE;
                end
            end
            btd_pkg::PH_LENMORE:
            begin
                r.byte_kind = btd_pkg::KIND_LEN;
                lacc_next = {lacc_reg[23:0], b};
                lbl_next = (lbl_reg != '0) ? lbl_reg - 7'd1 : lbl_reg;
                if (lbl_next == '0)
                begin
                    len_ready = 1'b1;
                end
            end
            btd_pkg::PH_VALUE:
            begin
                r.byte_kind = btd_pkg::KIND_VALUE;
                if (tag_reg == btd_pkg::TAG_INTEGER)
                begin
                    iacc_next = iacc_new;
                    if (vleft_reg == 32'd1)
                    begin
                        r.int_valid = 1'b1;
                        r.int_value = iacc_new;
                    end
                end
                else if (tag_reg == btd_pkg::TAG_OID)
                begin
                    if (first_reg)
                    begin
                        if (max_arcs < 8'd2)
                        begin
                            r.error_code = btd_pkg::ERR_ARCS;
                        end
                        else
                        begin
                            r.first_arc = q40;
                            r.arc_value = {24'd0, b - 8'(q40) * 8'd40};
                            r.arc_flag = btd_pkg::AFLAG_FIRST;
                            acnt_next = 8'd2;
                        end
                    end
                    else
                    begin
                        aacc_next = aacc_new;
                        if (!b[7])
                        begin
                            if (acnt_reg >= max_arcs)
                            begin
                                r.error_code = btd_pkg::ERR_ARCS;
                            end
                            else
                            begin
                                r.arc_value = aacc_new;
                                r.arc_flag = btd_pkg::AFLAG_LATER;
                                acnt_next = acnt_reg + 8'd1;
                                aacc_next = '0;
                            end
                        end
                    end
                end
                first_next = 1'b0;
                if (r.error_code != btd_pkg::ERR_NONE)
                begin
                    r.int_valid = 1'b0;
                    r.int_value = '0;
                    phase_next = btd_pkg::PH_DISCARD;
                end
                else
                begin
                    vleft_next = (vleft_reg != '0) ? vleft_reg - 32'd1 : vleft_reg;
                    if (vleft_next == '0)
                    begin
                        r.element_done = 1'b1;
                        phase_next = btd_pkg::PH_TAG;
                    end
                end
            end
            default:
            begin
                phase_next = btd_pkg::PH_DISCARD;
            end
        endcase

        if (len_ready)
        begin
            vleft_next = lacc_next;
            first_next = 1'b1;
            iacc_next = '0;
            aacc_next = '0;
            acnt_next = '0;
            if (tag_reg == btd_pkg::TAG_INTEGER &&
                (lacc_next < 32'd1 || lacc_next > 32'd8))
            begin
                r.error_code = btd_pkg::ERR_INT_SIZE;
                phase_next = btd_pkg::PH_DISCARD;
            end
            else if (tag_reg == btd_pkg::TAG_NULL && lacc_next != '0)
            begin
                r.error_code = btd_pkg::ERR_NULL_LEN;
                phase_next = btd_pkg::PH_DISCARD;
            end
            else if (tag_reg == btd_pkg::TAG_OID && lacc_next == '0)
            begin
                r.error_code = btd_pkg::ERR_EMPTY_OID;
                phase_next = btd_pkg::PH_DISCARD;
            end
            else if (lacc_next == '0)
            begin
                r.element_done = 1'b1;
                phase_next = btd_pkg::PH_TAG;
            end
            else
            begin
                phase_next = btd_pkg::PH_VALUE;
            end
        end

        r.tag_value = tag_next;
        r.content_length = lacc_next;

        if (q_req.buf_end)
        begin
            if (r.error_code == btd_pkg::ERR_NONE && phase_next != btd_pkg::PH_TAG &&
                phase_next != btd_pkg::PH_DISCARD)
            begin
                r.error_code = btd_pkg::ERR_TRUNCATED;
            end
            phase_next = btd_pkg::PH_TAG;
            tag_next = '0;
            lbl_next = '0;
            lacc_next = '0;
            vleft_next = '0;
            iacc_next = '0;
            aacc_next = '0;
            acnt_next = '0;
            first_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= btd_pkg::PH_TAG;
            tag_reg <= '0;
            lbl_reg <= '0;
            lacc_reg <= '0;
            vleft_reg <= '0;
            iacc_reg <= '0;
            aacc_reg <= '0;
            acnt_reg <= '0;
            first_reg <= 1'b1;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                tag_reg <= tag_next;
                lbl_reg <= lbl_next;
                lacc_reg <= lacc_next;
                vleft_reg <= vleft_next;
                iacc_reg <= iacc_next;
                aacc_reg <= aacc_next;
                acnt_reg <= acnt_next;
                first_reg <= first_next;
            end
            if (q_ready)
            begin
                ov_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= r;
        end
    end

endmodule

@@ rtl/ber_tlv_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_stream_decoder
// Parses a BER byte stream into TLV elements, one result per input byte.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  input    | in_valid, in_ready, in_byte, buf_end      | in
//  output   | out_valid, out_ready, byte_kind .. error  | out
//  config   | cfg_we, cfg_wdata (max_arcs)              | in
//
// One byte per cycle sustained while out_ready is high (input queue, then
// result register). Throughput is set by btd_back's per-byte parser step.
// Reset clears all parse state and sets max_arcs to 128.
// A stalled output fills the two-entry input queue, then drops in_ready.
// ----------------------------------------------------------------------------
module ber_tlv_stream_decoder #(
    parameter int MAX_LENGTH_BYTES = btd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               buf_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         byte_kind,
    output logic [7:0]         data_byte,
    output logic [7:0]         tag_value,
    output logic [31:0]        content_length,
    output logic               element_done,
    output logic signed [63:0] int_value,
    output logic               int_valid,
    output logic [2:0]         first_arc,
    output logic [31:0]        arc_value,
    output logic [1:0]         arc_flag,
    output logic [2:0]         error_code,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);

    logic [7:0]     max_arcs_reg;
    btd_pkg::req_t  req, q_req;
    btd_pkg::res_t  res;
    logic           q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_arcs_reg <= btd_pkg::MAX_ARCS_RESET;
        end
        else if (cfg_we)
        begin
            max_arcs_reg <= cfg_wdata;
        end
    end

    assign req.data_byte = in_byte;
    assign req.buf_end = buf_end;

    btd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .ready   (in_ready),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_req   (q_req)
    );

    btd_back #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .max_arcs  (max_arcs_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign byte_kind = res.byte_kind;
    assign data_byte = res.data_byte;
    assign tag_value = res.tag_value;
    assign content_length = res.content_length;
    assign element_done = res.element_done;
    assign int_value = res.int_value;
    assign int_valid = res.int_valid;
    assign first_arc = res.first_arc;
    assign arc_value = res.arc_value;
    assign arc_flag = res.arc_flag;
    assign error_code = res.error_code;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds BER buffers one byte per request into the TLV stream decoder and
// checks every per-byte result against a cycle-free decoder model, with
// random idling on both channels and max_arcs changed between phases.
// ----------------------------------------------------------------------------
import btd_pkg::*;

class tlv_scoreboard;
    res_t        expected_q[$];
    int          errors;
    logic [7:0]  max_arcs;
    phase_t      phase;
    logic [7:0]  tag_reg;
    logic [2:0]  len_left;
    logic [31:0] len_accum;
    logic [31:0] value_left;
    logic [63:0] int_accum;
    logic [31:0] arc_accum;
    logic [7:0]  arc_count;
    logic        first_content;

    function new();
        errors = 0;
        max_arcs = MAX_ARCS_RESET;
        clear_element();
    endfunction

    function void clear_element();
        phase = PH_TAG;
        tag_reg = '0;
        len_left = '0;
        len_accum = '0;
        value_left = '0;
        int_accum = '0;
        arc_accum = '0;
        arc_count = '0;
        first_content = 1'b1;
    endfunction

    function void note_request(logic [7:0] b, logic last);
        res_t e;
        logic len_ready;
        err_t err;
        logic [6:0] n;
        e = '0;
        len_ready = 1'b0;
        err = ERR_NONE;
        e.byte_kind = KIND_DISCARD;
        case (phase)
            PH_TAG:
            begin
                e.byte_kind = KIND_TAG;
                tag_reg = b;
                len_accum = '0;
                value_left = '0;
                phase = PH_LEN0;
            end
            PH_LEN0:
            begin
                e.byte_kind = KIND_LEN;
                if (!b[7])
                begin
                    len_accum = {24'd0, b};
                    len_ready = 1'b1;
                end
                else
                begin
                    n = b[6:0];
                    if (n < 1 || n > MAX_LENGTH_BYTES_DEF)
                    begin
                        err = ERR_LEN_COUNT;
                        phase = PH_DISCARD;
                    end
                    else
                    begin
                        len_left = n[2:0];
                        len_accum = '0;
                        phase = PH_LENMORE;
                    end
                end
            end
            PH_LENMORE:
            begin
                e.byte_kind = KIND_LEN;
                len_accum = {len_accum[23:0], b};
                if (len_left > 0)
                    len_left--;
                if (len_left == 0)
                    len_ready = 1'b1;
            end
            PH_VALUE:
            begin
                e.byte_kind = KIND_VALUE;
                if (tag_reg == TAG_INTEGER)
                begin
                    if (first_content)
                        int_accum = b[7] ? '1 : '0;
                    int_accum = {int_accum[55:0], b};
                    if (value_left == 1)
                    begin
                        e.int_valid = 1'b1;
                        e.int_value = int_accum;
                    end
                end
                else if (tag_reg == TAG_OID)
                begin
                    if (first_content)
                    begin
                        if (max_arcs < 2)
                            err = ERR_ARCS;
                        else
                        begin
                            e.first_arc = 3'(b / 40);
                            e.arc_value = 32'(b % 40);
                            e.arc_flag = AFLAG_FIRST;
                            arc_count = 8'd2;
                        end
                    end
                    else
                    begin
                        arc_accum = {arc_accum[24:0], b[6:0]};
                        if (!b[7])
                        begin
                            if (arc_count >= max_arcs)
                                err = ERR_ARCS;
                            else
                            begin
                                e.arc_value = arc_accum;
                                e.arc_flag = AFLAG_LATER;
                                arc_count++;
                                arc_accum = '0;
                            end
                        end
                    end
                end
                first_content = 1'b0;
                if (err != ERR_NONE)
                begin
                    e.int_valid = 1'b0;
                    e.int_value = '0;
                    e.first_arc = '0;
                    e.arc_value = '0;
                    e.arc_flag = AFLAG_NONE;
                    phase = PH_DISCARD;
                end
                else
                begin
                    if (value_left > 0)
                        value_left--;
                    if (value_left == 0)
                    begin
                        e.element_done = 1'b1;
                        phase = PH_TAG;
                    end
                end
            end
            default:
            begin
                e.byte_kind = KIND_DISCARD;
                phase = PH_DISCARD;
            end
        endcase
        if (len_ready)
        begin
            value_left = len_accum;
            first_content = 1'b1;
            int_accum = '0;
            arc_accum = '0;
            arc_count = '0;
            if (tag_reg == TAG_INTEGER && (len_accum < 1 || len_accum > 8))
            begin
                err = ERR_INT_SIZE;
                phase = PH_DISCARD;
            end
            else if (tag_reg == TAG_NULL && len_accum != 0)
            begin
                err = ERR_NULL_LEN;
                phase = PH_DISCARD;
            end
            else if (tag_reg == TAG_OID && len_accum == 0)
            begin
                err = ERR_EMPTY_OID;
                phase = PH_DISCARD;
            end
            else if (len_accum == 0)
            begin
                e.element_done = 1'b1;
                phase = PH_TAG;
            end
            else
                phase = PH_VALUE;
        end
        e.data_byte = b;
        e.tag_value = tag_reg;
        e.content_length = len_accum;
        if (last)
        begin
            if (err == ERR_NONE && phase != PH_TAG && phase != PH_DISCARD)
                err = ERR_TRUNCATED;
            clear_element();
        end
        e.error_code = err;
        expected_q.push_back(e);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(res_t act);
        res_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, actual %h", $time, act);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        compare("byte_kind", e.byte_kind, act.byte_kind);
        compare("data_byte", e.data_byte, act.data_byte);
        compare("tag_value", e.tag_value, act.tag_value);
        compare("content_length", e.content_length, act.content_length);
        compare("element_done", e.element_done, act.element_done);
        compare("int_value", e.int_value, act.int_value);
        compare("int_valid", e.int_valid, act.int_valid);
        compare("first_arc", e.first_arc, act.first_arc);
        compare("arc_value", e.arc_value, act.arc_value);
        compare("arc_flag", e.arc_flag, act.arc_flag);
        compare("error_code", e.error_code, act.error_code);
    endfunction
endclass

module testbench;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         in_byte = '0;
    logic               buf_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         byte_kind;
    logic [7:0]         data_byte;
    logic [7:0]         tag_value;
    logic [31:0]        content_length;
    logic               element_done;
    logic signed [63:0] int_value;
    logic               int_valid;
    logic [2:0]         first_arc;
    logic [31:0]        arc_value;
    logic [1:0]         arc_flag;
    logic [2:0]         error_code;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_wdata = '0;

    tlv_scoreboard sb = new();
    logic [8:0]    byte_q[$];
    int            rx_cycle = 0;
    int            rx_gap = 0;
    int            sent_count = 0;
    logic          stall_done = 1'b0;

    always #5 clk = ~clk;

    ber_tlv_stream_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .buf_end(buf_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .byte_kind(byte_kind), .data_byte(data_byte), .tag_value(tag_value),
        .content_length(content_length), .element_done(element_done),
        .int_value(int_value), .int_valid(int_valid), .first_arc(first_arc),
        .arc_value(arc_value), .arc_flag(arc_flag), .error_code(error_code),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({byte_kind, data_byte, tag_value, content_length, element_done,
                             int_value, int_valid, first_arc, arc_value, arc_flag,
                             error_code});
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!stall_done && sent_count >= 300)
            begin
                stall_done = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_cycle[9] && $urandom_range(0, 99) < 25)
                    rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic add_byte(logic [7:0] b, logic last = 1'b0);
        byte_q.push_back({last, b});
    endtask

    task automatic add_length(int unsigned n);
        case ($urandom_range(0, 5))
            0: begin add_byte(8'h81); add_byte(8'(n)); end
            1: begin add_byte(8'h82); add_byte(8'(n >> 8)); add_byte(8'(n)); end
            2:
            begin
                add_byte(8'h84); add_byte(8'(n >> 24)); add_byte(8'(n >> 16));
                add_byte(8'(n >> 8)); add_byte(8'(n));
            end
            default: add_byte(8'(n));
        endcase
    endtask

    task automatic add_buffer();
        int unsigned count;
        int unsigned n;
        int unsigned start;
        logic [8:0]  item;
        start = byte_q.size();
        count = $urandom_range(1, 4);
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    add_byte(TAG_INTEGER);
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 9
                                                    : $urandom_range(1, 8);
                    add_length(n);
                    repeat (n) add_byte(8'($urandom));
                end
                3:
                begin
                    add_byte(TAG_NULL);
                    n = ($urandom_range(0, 4) == 0) ? 1 : 0;
                    add_length(n);
                    repeat (n) add_byte(8'($urandom));
                end
                4, 5:
                begin
                    add_byte(TAG_OID);
                    n = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 10);
                    add_length(n);
                    repeat (n) add_byte(8'($urandom));
                end
                6:
                begin
                    add_byte(8'($urandom));
                    n = $urandom_range(0, 6);
                    add_length(n);
                    repeat (n) add_byte(8'($urandom));
                end
                7:
                begin
                    add_byte(8'($urandom));
                    add_byte(8'h84);
                    repeat (4) add_byte(8'($urandom));
                    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                end
                8:
                begin
                    add_byte(8'($urandom));
                    add_byte(($urandom_range(0, 2) == 0) ? 8'h80 : 8'($urandom_range(8'h85, 8'hFF)));
                    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                end
                default:
                    repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
            endcase
        end
        if ($urandom_range(0, 6) == 0 && byte_q.size() - start > 1)
        begin
            n = $urandom_range(1, byte_q.size() - start - 1);
            repeat (n) void'(byte_q.pop_back());
        end
        item = byte_q.pop_back();
        item[8] = 1'b1;
        byte_q.push_back(item);
    endtask

    task automatic send_all();
        logic [8:0] item;
        logic       taken;
        int         gap;
        while (byte_q.size() > 0)
        begin
            item = byte_q.pop_front();
            in_valid <= 1'b1;
            in_byte <= item[7:0];
            buf_end <= item[8];
            do
            begin
                @(negedge clk);
                taken = in_ready;
                @(posedge clk);
            end while (!taken);
            sb.note_request(item[7:0], item[8]);
            sent_count++;
            gap = $urandom_range(0, 99);
            gap = (gap < 70) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            if (byte_q.size() == 0 && gap == 0)
                gap = 1;
            if (gap > 0)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max_arcs(logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.max_arcs = v;
        @(posedge clk);
    endtask

    task automatic run_random(int unsigned items);
        int unsigned sent;
        sent = 0;
        while (sent < items)
        begin
            add_buffer();
            sent += byte_q.size();
            send_all();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_byte(TAG_INTEGER); add_byte(8'h01); add_byte(8'h80);
        add_byte(TAG_INTEGER); add_byte(8'h88); add_byte(8'h08);
        add_byte(8'h7F); repeat (7) add_byte(8'hFF);
        add_byte(TAG_NULL); add_byte(8'h00);
        add_byte(TAG_OID); add_byte(8'h03); add_byte(8'hFF); add_byte(8'h86);
        add_byte(8'h01, 1'b1);
        add_byte(TAG_OID); add_byte(8'h02); add_byte(8'h00); add_byte(8'h81, 1'b1);
        add_byte(TAG_OID); add_byte(8'h00); add_byte(8'h00, 1'b1);
        add_byte(TAG_NULL); add_byte(8'h01); add_byte(8'h00, 1'b1);
        add_byte(TAG_INTEGER); add_byte(8'h09); add_byte(8'h55, 1'b1);
        add_byte(TAG_INTEGER); add_byte(8'h00, 1'b1);
        add_byte(8'h30); add_byte(8'h80); add_byte(8'h00, 1'b1);
        add_byte(8'h30); add_byte(8'h85, 1'b1);
        add_byte(8'h04); add_byte(8'h84); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h00, 1'b1);
        send_all();
        wait_idle();

        write_max_arcs(8'd2);
        add_byte(TAG_OID); add_byte(8'h03); add_byte(8'h2B); add_byte(8'h06);
        add_byte(8'h01, 1'b1);
        run_random(120);
        wait_idle();

        write_max_arcs(8'd255);
        run_random(200);
        wait_idle();

        write_max_arcs(8'd3);
        run_random(150);
        wait_idle();

        write_max_arcs(8'($urandom_range(2, 255)));
        run_random(180);

        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
